// File: hdl/tl2tm_pkg.sv
package tl2tm_pkg;

	localparam int NUM_CONTEXTS_DEF = 4;
	localparam int NUM_VARS_DEF = 256;
	localparam int SET_DEPTH_DEF = 8;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam int KIND_W = 3;
	localparam int CTX_W = 2;
	localparam int VIDX_W = 8;
	localparam int DATA_W = 32;
	localparam int VER_W = 64;
	localparam int STAT_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_BEGIN = 3'd0,
		KIND_TX_READ = 3'd1,
		KIND_TX_WRITE = 3'd2,
		KIND_COMMIT = 3'd3,
		KIND_PLAIN_READ = 3'd4,
		KIND_PLAIN_WRITE = 3'd5,
		KIND_RSVD6 = 3'd6,
		KIND_RSVD7 = 3'd7
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 2'd0,
		ST_CONFLICT = 2'd1,
		ST_FULL = 2'd2,
		ST_NO_TX = 2'd3
	} status_t;

	// Result of one set search by the shared compare unit.
	typedef struct packed {
		logic hit;
		logic [5:0] pos;
	} search_res_t;

endpackage

// File: hdl/tl2tm_search.sv
// Shared compare unit: steps through a set looking for a variable. The set
// memories have a registered read, so each entry is first waited for until it
// arrives and then compared.
module tl2tm_search import tl2tm_pkg::*; #(
	parameter int SET_DEPTH = SET_DEPTH_DEF,
	parameter int VAR_W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [$clog2(SET_DEPTH+1)-1:0] count,
	input logic [VAR_W-1:0] key,
	input logic [VAR_W-1:0] entry,
	output logic [$clog2(SET_DEPTH+1)-1:0] idx,
	output logic done,
	output search_res_t res
);
	localparam int CW = $clog2(SET_DEPTH+1);
	logic busy_q;
	logic wait_q;
	logic [CW-1:0] idx_q;
	logic hit_q;

	assign idx = idx_q;
	assign done = busy_q && (hit_q || idx_q >= count);
	assign res.hit = hit_q;
	assign res.pos = 6'(idx_q);

	// Wait for the entry at idx_q, then compare it; stop on a hit or at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			wait_q <= 1'b0;
			idx_q <= '0;
			hit_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			wait_q <= 1'b1;
			idx_q <= '0;
			hit_q <= 1'b0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end else if (wait_q) begin
				wait_q <= 1'b0;
			end else if (entry == key) begin
				hit_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
				wait_q <= 1'b1;
			end
		end
	end
endmodule

// File: hdl/tl2_transaction_manager.sv
// Transaction manager for a TL2-style store of NUM_VARS versioned variables
// under a 64-bit global version clock, serving NUM_CONTEXTS contexts. One
// operation is accepted at a time, its kind on s_tuser, and exactly one result
// comes back; s_tready stays low from acceptance until that result has been
// taken. A single compare unit walks the per-context sets and waits for each
// entry it looks at before comparing it, because the set memories have a
// registered read. A transactional write walks the write set; a transactional
// read that misses the write set also walks the read set. A commit validates
// the read set and then applies the write set. After reset a clearing pass
// over all NUM_VARS entries zeros the variable store before the first
// transaction is accepted.
module tl2_transaction_manager import tl2tm_pkg::*; #(
	parameter int NUM_CONTEXTS = NUM_CONTEXTS_DEF,
	parameter int NUM_VARS = NUM_VARS_DEF,
	parameter int SET_DEPTH = SET_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// kind[2:0]
	input logic [2:0] s_tuser,
	// context_req[1:0], var_index[9:2], write_value[41:10]
	input logic [47:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// read_value[31:0], status[33:32], version[97:34]
	output logic [103:0] m_tdata
);
	localparam int VW = $clog2(NUM_VARS);
	localparam int CW = $clog2(SET_DEPTH+1);
	localparam int SW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
	localparam int XW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
	localparam int SETN = NUM_CONTEXTS*SET_DEPTH;
	localparam int AW = $clog2(SETN) > 0 ? $clog2(SETN) : 1;

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_WSRCH = 10'b0000000100,
		S_VAR = 10'b0000001000,
		S_RSRCH = 10'b0000010000,
		S_RD_END = 10'b0000100000,
		S_VALID = 10'b0001000000,
		S_VCHK = 10'b0010000000,
		S_APPLY = 10'b0100000000,
		S_OUT = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [KIND_W-1:0] kind_q;
	logic [XW-1:0] ctx_q;
	logic ctx_ok_q;
	logic [VW-1:0] var_q;
	logic [VALUE_WIDTH-1:0] wval_q;
	logic [VER_W-1:0] clock_q;
	logic [NUM_CONTEXTS-1:0] active_q;
	logic [VER_W-1:0] snap_q [NUM_CONTEXTS];
	logic [CW-1:0] rcnt_q [NUM_CONTEXTS];
	logic [CW-1:0] wcnt_q [NUM_CONTEXTS];
	logic [VW:0] clr_q;
	logic [CW-1:0] walk_q;
	logic [1:0] phase_q;
	logic [DATA_W-1:0] rval_q;
	logic [STAT_W-1:0] stat_q;
	logic [VER_W-1:0] ver_q;
	logic out_v_q;

	// Stores.
	logic [VALUE_WIDTH-1:0] vval_mem [NUM_VARS];
	logic [VER_W-1:0] vver_mem [NUM_VARS];
	logic [VW-1:0] rsv_mem [SETN];
	logic [VER_W-1:0] rsr_mem [SETN];
	logic [VW-1:0] wsv_mem [SETN];
	logic [VALUE_WIDTH-1:0] wsd_mem [SETN];
	logic [VALUE_WIDTH-1:0] vval_rd_q;
	logic [VER_W-1:0] vver_rd_q;
	logic [VW-1:0] rsv_rd_q;
	logic [VER_W-1:0] rsr_rd_q;
	logic [VW-1:0] wsv_rd_q;
	logic [VALUE_WIDTH-1:0] wsd_rd_q;

	logic [VW-1:0] var_rd_addr;
	logic [AW-1:0] set_rd_addr;
	logic [CW-1:0] srch_idx;
	logic srch_start, srch_done;
	logic [CW-1:0] srch_cnt;
	logic [VW-1:0] srch_entry;
	search_res_t srch_res;
	logic srch_rs_q;
	logic [CW-1:0] rcnt_c, wcnt_c;

	logic in_acc;
	logic [KIND_W-1:0] in_kind;
	logic [CTX_W-1:0] in_ctx;

	assign in_acc = s_tvalid && s_tready;
	assign in_kind = s_tuser;
	assign in_ctx = s_tdata[1:0];
	assign s_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = {6'd0, ver_q, stat_q, rval_q};
	assign rcnt_c = rcnt_q[ctx_q];
	assign wcnt_c = wcnt_q[ctx_q];

	function automatic logic [AW-1:0] set_addr(input logic [XW-1:0] c,
		input logic [CW-1:0] i);
		set_addr = AW'(c * SET_DEPTH + i[SW-1:0]);
	endfunction

	// The compare unit walks either the write set or the read set.
	assign srch_cnt = srch_rs_q ? rcnt_c : wcnt_c;
	assign srch_entry = srch_rs_q ? rsv_rd_q : wsv_rd_q;
	assign srch_start = (state_q == S_IDLE && in_acc) || (state_q == S_VAR);

	tl2tm_search #(.SET_DEPTH(SET_DEPTH), .VAR_W(VW)) u_search (
		.clk(clk), .arst_n(arst_n), .start(srch_start), .count(srch_cnt),
		.key(var_q), .entry(srch_entry), .idx(srch_idx), .done(srch_done),
		.res(srch_res)
	);

	// Read addresses: set entry under search or walk, and the variable.
	always_comb begin
		var_rd_addr = var_q;
		set_rd_addr = set_addr(ctx_q, srch_idx);
		if (state_q == S_VALID || state_q == S_VCHK || state_q == S_APPLY) begin
			set_rd_addr = set_addr(ctx_q, walk_q);
		end
		if (state_q == S_VCHK) begin
			var_rd_addr = rsv_rd_q;
		end
	end

	// Registered memory reads.
	always_ff @(posedge clk) begin
		vval_rd_q <= vval_mem[var_rd_addr];
		vver_rd_q <= vver_mem[var_rd_addr];
		rsv_rd_q <= rsv_mem[set_rd_addr];
		rsr_rd_q <= rsr_mem[set_rd_addr];
		wsv_rd_q <= wsv_mem[set_rd_addr];
		wsd_rd_q <= wsd_mem[set_rd_addr];
	end

	// Variable store writes: clearing pass, commit apply and plain write.
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			vval_mem[clr_q[VW-1:0]] <= '0;
			vver_mem[clr_q[VW-1:0]] <= '0;
		end else if (state_q == S_APPLY && phase_q == 2'd1) begin
			vval_mem[wsv_rd_q] <= wsd_rd_q;
			vver_mem[wsv_rd_q] <= clock_q;
		end else if (state_q == S_VAR && kind_q == KIND_PLAIN_WRITE) begin
			vval_mem[var_q] <= wval_q;
			vver_mem[var_q] <= clock_q;
		end
	end

	// Set memory writes: append on tx read or write, update on write hit.
	always_ff @(posedge clk) begin
		if (state_q == S_RD_END && !srch_res.hit && vver_rd_q <= snap_q[ctx_q]
			&& rcnt_c < CW'(SET_DEPTH)) begin
			rsv_mem[set_addr(ctx_q, rcnt_c)] <= var_q;
			rsr_mem[set_addr(ctx_q, rcnt_c)] <= vver_rd_q;
		end
		if (state_q == S_WSRCH && srch_done && kind_q == KIND_TX_WRITE) begin
			if (srch_res.hit) begin
				wsd_mem[set_addr(ctx_q, srch_idx)] <= wval_q;
			end else if (wcnt_c < CW'(SET_DEPTH)) begin
				wsv_mem[set_addr(ctx_q, wcnt_c)] <= var_q;
				wsd_mem[set_addr(ctx_q, wcnt_c)] <= wval_q;
			end
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			clock_q <= '0;
			active_q <= '0;
			for (int i = 0; i < NUM_CONTEXTS; i++) begin
				snap_q[i] <= '0;
				rcnt_q[i] <= '0;
				wcnt_q[i] <= '0;
			end
			out_v_q <= 1'b0;
			kind_q <= '0;
			ctx_q <= '0;
			ctx_ok_q <= 1'b0;
			var_q <= '0;
			wval_q <= '0;
			rval_q <= '0;
			stat_q <= ST_OK;
			ver_q <= '0;
			srch_rs_q <= 1'b0;
			walk_q <= '0;
			phase_q <= '0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (VW+1)'(NUM_VARS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						kind_q <= in_kind;
						ctx_q <= XW'(in_ctx);
						ctx_ok_q <= 32'(in_ctx) < NUM_CONTEXTS;
						var_q <= VW'(s_tdata[9:2]);
						wval_q <= VALUE_WIDTH'(s_tdata[41:10]);
						rval_q <= '0;
						stat_q <= ST_OK;
						ver_q <= '0;
						srch_rs_q <= 1'b0;
						state_q <= S_WSRCH;
					end
				end
				S_WSRCH: begin
					if (kind_q <= KIND_COMMIT && !ctx_ok_q) begin
						stat_q <= ST_NO_TX;
						state_q <= S_OUT;
					end else if (kind_q == KIND_BEGIN) begin
						rcnt_q[ctx_q] <= '0;
						wcnt_q[ctx_q] <= '0;
						active_q[ctx_q] <= 1'b1;
						snap_q[ctx_q] <= clock_q;
						ver_q <= clock_q;
						state_q <= S_OUT;
					end else if (kind_q <= KIND_COMMIT && !active_q[ctx_q]) begin
						stat_q <= ST_NO_TX;
						state_q <= S_OUT;
					end else if (kind_q == KIND_COMMIT) begin
						clock_q <= clock_q + 1'b1;
						walk_q <= '0;
						phase_q <= '0;
						state_q <= S_VALID;
					end else if (kind_q == KIND_PLAIN_READ) begin
						state_q <= S_VAR;
					end else if (kind_q == KIND_PLAIN_WRITE) begin
						clock_q <= clock_q + 1'b1;
						state_q <= S_VAR;
					end else if (kind_q == KIND_TX_READ || kind_q == KIND_TX_WRITE) begin
						if (srch_done) begin
							if (kind_q == KIND_TX_READ) begin
								if (srch_res.hit) begin
									rval_q <= DATA_W'(wsd_rd_q);
									state_q <= S_OUT;
								end else begin
									srch_rs_q <= 1'b1;
									state_q <= S_VAR;
								end
							end else begin
								if (!srch_res.hit) begin
									if (wcnt_c < CW'(SET_DEPTH)) begin
										wcnt_q[ctx_q] <= wcnt_c + 1'b1;
									end else begin
										stat_q <= ST_FULL;
										active_q[ctx_q] <= 1'b0;
										rcnt_q[ctx_q] <= '0;
										wcnt_q[ctx_q] <= '0;
									end
								end
								state_q <= S_OUT;
							end
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_VAR: begin
					if (kind_q == KIND_PLAIN_WRITE) begin
						ver_q <= clock_q;
						state_q <= S_OUT;
					end else if (kind_q == KIND_PLAIN_READ) begin
						state_q <= S_RD_END;
					end else begin
						state_q <= S_RSRCH;
					end
				end
				S_RSRCH: begin
					if (srch_done) begin
						state_q <= S_RD_END;
					end
				end
				S_RD_END: begin
					if (kind_q == KIND_PLAIN_READ) begin
						rval_q <= DATA_W'(vval_rd_q);
					end else if (vver_rd_q > snap_q[ctx_q]) begin
						stat_q <= ST_CONFLICT;
						active_q[ctx_q] <= 1'b0;
						rcnt_q[ctx_q] <= '0;
						wcnt_q[ctx_q] <= '0;
					end else if (!srch_res.hit && rcnt_c >= CW'(SET_DEPTH)) begin
						stat_q <= ST_FULL;
						active_q[ctx_q] <= 1'b0;
						rcnt_q[ctx_q] <= '0;
						wcnt_q[ctx_q] <= '0;
					end else begin
						if (!srch_res.hit) begin
							rcnt_q[ctx_q] <= rcnt_c + 1'b1;
						end
						rval_q <= DATA_W'(vval_rd_q);
					end
					state_q <= S_OUT;
				end
				// Validation: read-set entry, then its variable's version.
				S_VALID: begin
					if (walk_q >= rcnt_c) begin
						walk_q <= '0;
						phase_q <= '0;
						state_q <= S_APPLY;
					end else begin
						state_q <= S_VCHK;
						phase_q <= '0;
					end
				end
				S_VCHK: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == 2'd1) begin
						if (vver_rd_q != rsr_rd_q) begin
							stat_q <= ST_CONFLICT;
							active_q[ctx_q] <= 1'b0;
							rcnt_q[ctx_q] <= '0;
							wcnt_q[ctx_q] <= '0;
							state_q <= S_OUT;
						end else begin
							walk_q <= walk_q + 1'b1;
							state_q <= S_VALID;
						end
					end
				end
				S_APPLY: begin
					if (walk_q >= wcnt_c) begin
						ver_q <= clock_q;
						active_q[ctx_q] <= 1'b0;
						rcnt_q[ctx_q] <= '0;
						wcnt_q[ctx_q] <= '0;
						state_q <= S_OUT;
					end else if (phase_q == 2'd1) begin
						phase_q <= '0;
						walk_q <= walk_q + 1'b1;
					end else begin
						phase_q <= 2'd1;
					end
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result never appears while a new operation can still be accepted.
	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accept while result pending");
	// A pending result holds until taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped");
	// In idle, context 0 when closed keeps no set entries.
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && !active_q[0] |-> rcnt_q[0] == '0 && wcnt_q[0] == '0)
		else $error("closed context has entries");
endmodule
